[hdl/imhq_pkg.sv]
// Package for the indexed min-heap queue: request/result structs and codes.
// No dependencies.
`timescale 1ns / 1ps
package imhq_pkg;
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_DUP     = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] new_key;
    logic [7:0]  item_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_key;
    logic [7:0]  out_handle;
    logic [8:0]  entry_count;
  } res_t;
endpackage

[hdl/imhq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[hdl/indexed_min_heap_queue.sv]
// Indexed binary min-heap queue: push, pop-minimum and update-key requests. Uses imhq_pkg, imhq_ram.
// Rejected requests and unused kinds go from the check straight to the result; a push sifts up,
// a pop reads root and last entry and sifts down, an update sifts up, then down if it did not move.
// One request at a time; start is next taken at the edge that ends the result cycle.
// The result is shown for one cycle with done high; the receiver cannot stall.
// Synchronous active-high reset clears count, present bits and control state.
`timescale 1ns / 1ps
module indexed_min_heap_queue #(
  parameter int CAPACITY = 256,
  parameter int KEY_BITS = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  imhq_pkg::req_t  req,
  output logic            busy,
  output logic            done,
  output imhq_pkg::res_t  res
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;         // child index, wide enough not to wrap
  localparam int EW = KEY_BITS + 8;   // key and handle stored together

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;  // present bit and position known
  localparam logic [3:0] S_POP_ROOT = 4'd2;  // root entry on read data
  localparam logic [3:0] S_POP_LAST = 4'd3;  // last entry on read data
  localparam logic [3:0] S_UP_RD    = 4'd4;  // parent read issued
  localparam logic [3:0] S_UP_CMP   = 4'd5;  // parent compare and move
  localparam logic [3:0] S_DN_L     = 4'd6;  // left child read issued
  localparam logic [3:0] S_DN_R     = 4'd7;  // left compare, right read issued
  localparam logic [3:0] S_DN_CMP   = 4'd8;  // right compare and move
  localparam logic [3:0] S_PLACE    = 4'd9;  // final placement
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state, state_next;

  // heap RAM, holds {key, handle}
  logic          h_we;
  logic [AW-1:0] h_waddr, h_raddr;
  logic [EW-1:0] h_wdata, h_rdata;

  // position table indexed by handle
  logic          p_we;
  logic [7:0]    p_waddr, p_raddr;
  logic [AW-1:0] p_wdata, p_rdata;

  logic [255:0]        present;
  logic [CW-1:0]       count;
  imhq_pkg::req_t      rq;
  logic [KEY_BITS-1:0] mkey;         // the entry being sifted
  logic [7:0]          mhnd;
  logic [AW-1:0]       slot;
  logic                try_down;     // update: sift down if no upward move
  logic [EW-1:0]       lent;         // left child entry
  logic                lwin;         // left child beat the moving entry
  logic [KEY_BITS-1:0] bkey;         // best key so far at this level

  logic [KEY_BITS-1:0] in_key, rd_key;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_lt;
  logic [AW-1:0]       parent;
  logic [IW-1:0]       lidx, ridx;
  logic                l_in, r_in;

  imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata));

  imhq_ram #(.WIDTH(AW), .DEPTH(256)) u_pos (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  assign in_key = KEY_BITS'(rq.new_key);
  assign rd_key = h_rdata[EW-1:8];

  // shared comparator: a < b
  assign cmp_lt = cmp_a < cmp_b;

  assign parent = (slot - AW'(1)) >> 1;
  assign lidx   = IW'({slot, 1'b1});
  assign ridx   = lidx + IW'(1);
  assign l_in   = lidx < IW'(count);
  assign r_in   = ridx < IW'(count);

  always_comb begin
    state_next = state;
    h_we = 1'b0; h_waddr = slot; h_wdata = {mkey, mhnd}; h_raddr = slot;
    p_we = 1'b0; p_waddr = mhnd; p_wdata = slot;
    p_raddr = (state == S_IDLE) ? req.item_handle : rq.item_handle;
    cmp_a = mkey; cmp_b = rd_key;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = S_DONE;
        case (rq.kind)
          imhq_pkg::KIND_PUSH: begin
            if (!present[rq.item_handle] && count != CW'(CAPACITY)) state_next = S_UP_RD;
          end
          imhq_pkg::KIND_POP: begin
            h_raddr = '0;
            if (count != '0) state_next = S_POP_ROOT;
          end
          imhq_pkg::KIND_UPDATE: begin
            if (present[rq.item_handle]) state_next = S_UP_RD;
          end
          default: ;
        endcase
      end
      S_POP_ROOT: begin
        h_raddr = AW'(count - CW'(1));
        state_next = S_POP_LAST;
      end
      S_POP_LAST: begin
        state_next = (count == '0) ? S_DONE : S_DN_L;
      end
      S_UP_RD: begin
        if (slot == '0) begin
          state_next = try_down ? S_DN_L : S_PLACE;
        end else begin
          h_raddr = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // parent strictly bigger: move it down into this slot
        if (cmp_lt) begin
          h_we = 1'b1; h_wdata = h_rdata;
          p_we = 1'b1; p_waddr = h_rdata[7:0];
          state_next = S_UP_RD;
        end else begin
          state_next = try_down ? S_DN_L : S_PLACE;
        end
      end
      S_DN_L: begin
        if (l_in) begin
          h_raddr = lidx[AW-1:0];
          state_next = S_DN_R;
        end else begin
          state_next = S_PLACE;
        end
      end
      S_DN_R: begin
        cmp_a = rd_key; cmp_b = mkey;
        h_raddr = ridx[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        // right child wins only when strictly below the best so far
        cmp_a = rd_key; cmp_b = bkey;
        state_next = S_DN_L;
        if (r_in && cmp_lt) begin
          h_we = 1'b1; h_wdata = h_rdata;
          p_we = 1'b1; p_waddr = h_rdata[7:0];
        end else if (lwin) begin
          h_we = 1'b1; h_wdata = lent;
          p_we = 1'b1; p_waddr = lent[7:0];
        end else begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        h_we = 1'b1; p_we = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // the sequencer's datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; present <= '0; count <= '0; done <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
      case (state)
        S_IDLE: begin
          if (start) begin
            rq <= req; res <= '0;
          end
        end
        S_CHECK: begin
          mkey <= in_key; mhnd <= rq.item_handle; try_down <= 1'b0;
          case (rq.kind)
            imhq_pkg::KIND_PUSH: begin
              if (present[rq.item_handle]) res.status <= imhq_pkg::ST_DUP;
              else if (count == CW'(CAPACITY)) res.status <= imhq_pkg::ST_FULL;
              else begin
                present[rq.item_handle] <= 1'b1;
                count <= count + CW'(1);
                slot <= AW'(count);
              end
            end
            imhq_pkg::KIND_POP: begin
              if (count == '0) res.status <= imhq_pkg::ST_EMPTY;
            end
            imhq_pkg::KIND_UPDATE: begin
              if (!present[rq.item_handle]) res.status <= imhq_pkg::ST_UNKNOWN;
              else begin
                slot <= p_rdata; try_down <= 1'b1;
              end
            end
            default: ;
          endcase
        end
        S_POP_ROOT: begin
          res.out_key    <= 32'(rd_key);
          res.out_handle <= h_rdata[7:0];
          present[h_rdata[7:0]] <= 1'b0;
          count <= count - CW'(1);
        end
        S_POP_LAST: begin
          // last entry goes to the root and sifts down
          mkey <= rd_key; mhnd <= h_rdata[7:0]; slot <= '0;
        end
        S_UP_CMP: begin
          if (cmp_lt) begin
            slot <= parent; try_down <= 1'b0;
          end
        end
        S_DN_R: begin
          lent <= h_rdata;
          lwin <= cmp_lt;
          bkey <= cmp_lt ? rd_key : mkey;
        end
        S_DN_CMP: begin
          if (r_in && cmp_lt) slot <= ridx[AW-1:0];
          else if (lwin) slot <= lidx[AW-1:0];
        end
        S_DONE: res.entry_count <= 9'(count);
        default: ;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  assert property (@(posedge clk) disable iff (rst) (state == S_DONE) |=> done)
    else $error("missing result strobe");

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("busy during result cycle");

  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("count beyond capacity");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_CHECK))
    else $error("request not taken");
endmodule
